### rtl/core/swmf_pkg.sv
// Shared types and constants of the sliding window median filter.
// Used by swmf_ring, sliding_window_median_filter and the testbench; depends on nothing else.
package swmf_pkg;

   localparam int WINDOW_DEFAULT = 16;
   localparam int SAMPLE_W       = 10;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 24;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PRIME,
      ST_SWEEP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctl_type;

endpackage

### rtl/core/swmf_ring.sv
// Arrival-order ring of window samples with its write pointer and per-entry valid bits.
// Depends on swmf_pkg for the sample width and the control struct.
module swmf_ring #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swmf_pkg::ring_ctl_type        ctl,
   input  logic [swmf_pkg::SAMPLE_W-1:0] wr_data,
   output logic [swmf_pkg::SAMPLE_W-1:0] rd_data
);

   localparam int IDX_W = $clog2(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   logic [swmf_pkg::SAMPLE_W-1:0] ring_mem [WINDOW];
   logic [swmf_pkg::SAMPLE_W-1:0] rd_q_ff;
   logic                          rd_valid_ff;
   logic [WINDOW-1:0]             valid_ff;
   logic [WINDOW-1:0]             valid_in;
   logic [IDX_W-1:0]              wp_ff;
   logic [IDX_W-1:0]              wp_in;

   always_comb begin
      valid_in = valid_ff;
      wp_in    = wp_ff;
      if (ctl.wr_en) begin
         valid_in[wp_ff] = 1'b1;
         wp_in           = (wp_ff == LAST_IDX) ? '0 : wp_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wp_ff    <= '0;
      end else begin
         valid_ff <= valid_in;
         wp_ff    <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         ring_mem[wp_ff] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff     <= ring_mem[wp_ff];
         rd_valid_ff <= valid_ff[wp_ff];
      end
   end

   // Entries never written since reset read as zero.
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

### rtl/core/sliding_window_median_filter.sv
// Top level of the sliding window median filter: handshakes, sequencer and sorted copy.
// Depends on swmf_pkg and instantiates swmf_ring.
//
// Channel  Direction  Handshake                       Payload
// req      in         req_tvalid / req_tready         req_tdata: sample_value
// rsp      out        rsp_tvalid / rsp_tready         rsp_tdata: sample_echo, median_value
//
// Between one accepted request and the next, an item makes one pass over the sorted-copy memory,
// one entry per cycle, read ahead on one port and written back on a separate write port.
// Reset clears the window through valid bits, so no clearing pass is needed.
// A result waits in the output register while the next request is processed;
// only a result that finds that register still full holds the sequencer.
module sliding_window_median_filter #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [swmf_pkg::REQ_TDATA_W-1:0] req_tdata,  // [9:0] sample_value
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [swmf_pkg::RSP_TDATA_W-1:0] rsp_tdata   // [9:0] sample_echo, [19:10] median_value
);

   localparam int SW    = swmf_pkg::SAMPLE_W;
   localparam int IDX_W = $clog2(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
   localparam logic [IDX_W-1:0] MID_IDX  = IDX_W'(WINDOW / 2);
   localparam logic [IDX_W:0]   DEPTH    = (IDX_W + 1)'(WINDOW);

   swmf_pkg::state_type    state_ff, state_in;
   swmf_pkg::ring_ctl_type ring_ctl;

   logic [SW-1:0]    sample_ff, sample_in;
   logic [SW-1:0]    cur_ff, cur_in;
   logic [SW-1:0]    tprev_ff, tprev_in;
   logic [SW-1:0]    median_ff, median_in;
   logic [SW-1:0]    echo_ff, echo_in;
   logic [SW-1:0]    rsp_median_ff, rsp_median_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic             drop_ff, drop_in;
   logic             primed_ff, primed_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [SW-1:0]    sort_mem [WINDOW];
   logic [SW-1:0]    sq_ff;
   logic             sort_rd_en;
   logic [IDX_W-1:0] sort_rd_addr;
   logic             sort_wr_en;

   logic [SW-1:0]    old_sample;
   logic [SW-1:0]    s_next;
   logic [SW-1:0]    t_k;
   logic [SW-1:0]    sort_out;
   logic [IDX_W:0]   ahead_idx;
   logic             drop_k;
   logic             t_ok;
   logic             prev_ok;
   logic             is_last;

   swmf_ring #(
      .WINDOW(WINDOW)
   ) u_ring (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ring_ctl),
      .wr_data(sample_ff),
      .rd_data(old_sample)
   );

   // One step of removing the oldest sample from the sorted copy and inserting the new one.
   always_comb begin
      is_last   = (step_ff == LAST_IDX);
      s_next    = primed_ff ? sq_ff : '0;
      drop_k    = drop_ff | (cur_ff == old_sample);
      t_k       = drop_k ? s_next : cur_ff;
      t_ok      = !is_last && (t_k <= sample_ff);
      prev_ok   = (step_ff == '0) || (tprev_ff <= sample_ff);
      sort_out  = t_ok ? t_k : (prev_ok ? sample_ff : tprev_ff);
      ahead_idx = {1'b0, step_ff} + (IDX_W + 1)'(2);
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      cur_in        = cur_ff;
      tprev_in      = tprev_ff;
      median_in     = median_ff;
      echo_in       = echo_ff;
      rsp_median_in = rsp_median_ff;
      step_in       = step_ff;
      drop_in       = drop_ff;
      primed_in     = primed_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      req_tready    = 1'b0;
      ring_ctl      = '0;
      sort_rd_en    = 1'b0;
      sort_rd_addr  = '0;
      sort_wr_en    = 1'b0;

      unique case (state_ff)
         swmf_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sample_in = req_tdata[SW-1:0];
               state_in  = swmf_pkg::ST_FETCH;
            end
         end
         swmf_pkg::ST_FETCH: begin
            ring_ctl.rd_en = 1'b1;
            sort_rd_en     = 1'b1;
            sort_rd_addr   = '0;
            state_in       = swmf_pkg::ST_PRIME;
         end
         swmf_pkg::ST_PRIME: begin
            ring_ctl.wr_en = 1'b1;
            cur_in         = s_next;
            sort_rd_en     = 1'b1;
            sort_rd_addr   = IDX_W'(1);
            drop_in        = 1'b0;
            step_in        = '0;
            state_in       = swmf_pkg::ST_SWEEP;
         end
         swmf_pkg::ST_SWEEP: begin
            sort_wr_en = 1'b1;
            cur_in     = s_next;
            tprev_in   = t_k;
            drop_in    = drop_k;
            if (step_ff == MID_IDX) begin
               median_in = sort_out;
            end
            if (ahead_idx < DEPTH) begin
               sort_rd_en   = 1'b1;
               sort_rd_addr = ahead_idx[IDX_W-1:0];
            end
            if (is_last) begin
               primed_in = 1'b1;
               state_in  = swmf_pkg::ST_FLUSH;
            end else begin
               step_in = step_ff + IDX_W'(1);
            end
         end
         swmf_pkg::ST_FLUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               echo_in       = sample_ff;
               rsp_median_in = median_ff;
               state_in      = swmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = swmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swmf_pkg::ST_IDLE;
         step_ff      <= '0;
         drop_ff      <= 1'b0;
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         drop_ff      <= drop_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      cur_ff        <= cur_in;
      tprev_ff      <= tprev_in;
      median_ff     <= median_in;
      echo_ff       <= echo_in;
      rsp_median_ff <= rsp_median_in;
   end

   always_ff @(posedge clock) begin
      if (sort_wr_en) begin
         sort_mem[step_ff] <= sort_out;
      end
      if (sort_rd_en) begin
         sq_ff <= sort_mem[sort_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(swmf_pkg::RSP_TDATA_W - 2 * SW)'(0), rsp_median_ff, echo_ff};

   a_accept_starts_fetch: assert property (
      @(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == swmf_pkg::ST_FETCH
   ) else $error("accepted request did not start a window update");

   a_sweep_runs_full: assert property (
      @(posedge clock) disable iff (reset)
      state_ff == swmf_pkg::ST_SWEEP && step_ff != LAST_IDX |=> state_ff == swmf_pkg::ST_SWEEP
   ) else $error("sorted-copy pass ended early");

   a_flush_after_sweep: assert property (
      @(posedge clock) disable iff (reset)
      $rose(state_ff == swmf_pkg::ST_FLUSH) |-> $past(step_ff) == LAST_IDX && primed_ff
   ) else $error("result staged before the pass covered the whole window");

   a_result_needs_flush: assert property (
      @(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == swmf_pkg::ST_FLUSH
   ) else $error("result raised outside the flush step");

endmodule

### sim/tb.sv
// Self-checking testbench for sliding_window_median_filter: a directed table, then random
// samples under several idling mixes, with every result checked against a window predictor.
// Depends on swmf_pkg and the RTL of sliding_window_median_filter.
`timescale 1ns / 1ps

module tb;

   localparam int WINDOW           = swmf_pkg::WINDOW_DEFAULT;
   localparam int SAMPLE_W         = swmf_pkg::SAMPLE_W;
   localparam int REQ_TDATA_W      = swmf_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W      = swmf_pkg::RSP_TDATA_W;
   localparam int MID_RANK         = WINDOW / 2;
   localparam int RANDOM_PER_PHASE = 175;
   localparam int DRAIN_CYCLES     = 2 * (WINDOW + 4);
   localparam int CYCLE_LIMIT      = 400000;
   localparam int DIRECTED_COUNT   = 25;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] echo;
      logic [SAMPLE_W-1:0] median;
   } filter_result_type;

   typedef struct packed {
      logic [REQ_TDATA_W-1:0] word;
      logic                   typed;
      logic [SAMPLE_W-1:0]    echo;
      logic [SAMPLE_W-1:0]    median;
   } directed_row_type;

   // Warm-up with reset zeros, upper median at the half-full point, wide inputs and duplicates.
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'h03FF, 1'b1, 10'd1023, 10'd0},
      '{16'hFFFF, 1'b1, 10'd1023, 10'd0},
      '{16'h07FF, 1'b1, 10'd1023, 10'd0},
      '{16'hABFF, 1'b1, 10'd1023, 10'd0},
      '{16'h57FF, 1'b1, 10'd1023, 10'd0},
      '{16'h0FFF, 1'b1, 10'd1023, 10'd0},
      '{16'hF3FF, 1'b1, 10'd1023, 10'd0},
      '{16'h03FF, 1'b1, 10'd1023, 10'd1023},
      '{16'h0000, 1'b1, 10'd0,    10'd1023},
      '{16'hFC00, 1'b1, 10'd0,    10'd1023},
      '{16'h0400, 1'b1, 10'd0,    10'd1023},
      '{16'h8000, 1'b1, 10'd0,    10'd1023},
      '{16'h2C00, 1'b1, 10'd0,    10'd1023},
      '{16'h5000, 1'b1, 10'd0,    10'd1023},
      '{16'hA400, 1'b1, 10'd0,    10'd1023},
      '{16'h0000, 1'b1, 10'd0,    10'd1023},
      '{16'h0001, 1'b1, 10'd1,    10'd1},
      '{16'hFC01, 1'b1, 10'd1,    10'd1},
      '{16'h0401, 1'b1, 10'd1,    10'd1},
      '{16'h8001, 1'b1, 10'd1,    10'd1},
      '{16'h5401, 1'b1, 10'd1,    10'd1},
      '{16'hA801, 1'b1, 10'd1,    10'd1},
      '{16'h0001, 1'b1, 10'd1,    10'd1},
      '{16'h0001, 1'b1, 10'd1,    10'd1},
      '{16'h02AA, 1'b0, 10'd0,    10'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [9:0] sample_value
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [9:0] sample_echo, [19:10] median_value

   logic [SAMPLE_W-1:0] window_ring [WINDOW];
   int                  ring_slot;
   filter_result_type   pending_results [$];
   int                  accepted_count = 0;
   int                  results_seen = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;

   sliding_window_median_filter #(.WINDOW(WINDOW)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < WINDOW; i++) begin
         window_ring[i] = '0;
      end
      ring_slot = 0;
   end

   function automatic filter_result_type store_and_rank(logic [REQ_TDATA_W-1:0] word);
      filter_result_type outcome;
      int                below;
      int                not_above;
      outcome.echo = word[SAMPLE_W-1:0];
      outcome.median = '0;
      window_ring[ring_slot] = word[SAMPLE_W-1:0];
      ring_slot = (ring_slot + 1 >= WINDOW) ? 0 : ring_slot + 1;
      for (int i = 0; i < WINDOW; i++) begin
         below = 0;
         not_above = 0;
         for (int k = 0; k < WINDOW; k++) begin
            below += (window_ring[k] < window_ring[i]) ? 1 : 0;
            not_above += (window_ring[k] <= window_ring[i]) ? 1 : 0;
         end
         if (below <= MID_RANK && not_above > MID_RANK) begin
            outcome.median = window_ring[i];
         end
      end
      return outcome;
   endfunction

   function automatic logic [REQ_TDATA_W-1:0] random_sample_word();
      logic [SAMPLE_W-1:0]             value;
      logic [REQ_TDATA_W-SAMPLE_W-1:0] upper;
      case ($urandom_range(7))
         0: begin
            value = '0;
         end
         1: begin
            value = 10'd1023;
         end
         2: begin
            value = SAMPLE_W'($urandom_range(15));
         end
         3: begin
            value = SAMPLE_W'(1023 - $urandom_range(15));
         end
         4: begin
            value = SAMPLE_W'(500 + $urandom_range(24));
         end
         default: begin
            value = SAMPLE_W'($urandom_range(1023));
         end
      endcase
      upper = ($urandom_range(3) == 0) ? (REQ_TDATA_W-SAMPLE_W)'($urandom_range(63)) : '0;
      return {upper, value};
   endfunction

   task automatic send_sample(input logic [REQ_TDATA_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic note_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                input logic [SAMPLE_W-1:0] got);
      if (error_count < REPORT_LIMIT) begin
         $display("Mismatch on result %0d, %s: expected %0d, got %0d",
                  results_seen, what, want, got);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      filter_result_type want;
      filter_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = store_and_rank(req_tdata);
            if (accepted_count < DIRECTED_COUNT && DIRECTED_ROWS[accepted_count].typed) begin
               want.echo = DIRECTED_ROWS[accepted_count].echo;
               want.median = DIRECTED_ROWS[accepted_count].median;
            end
            pending_results.push_back(want);
            accepted_count <= accepted_count + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.echo = rsp_tdata[SAMPLE_W-1:0];
            got.median = rsp_tdata[2*SAMPLE_W-1:SAMPLE_W];
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("Unexpected transaction: echo %0d, median %0d",
                           got.echo, got.median);
               end
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.echo != want.echo) begin
                  note_mismatch("sample_echo", want.echo, got.echo);
               end
               if (got.median != want.median) begin
                  note_mismatch("median_value", want.median, got.median);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out with %0d results outstanding.", pending_results.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      int items_sent;
      items_sent = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int r = 0; r < DIRECTED_COUNT; r++) begin
         send_sample(DIRECTED_ROWS[r].word);
         items_sent++;
      end
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct <= 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct <= 45;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct <= 0;
               stall_pct <= 45;
            end
            default: begin
               send_idle_pct <= 32;
               stall_pct <= 32;
            end
         endcase
         repeat (RANDOM_PER_PHASE) begin
            send_sample(random_sample_word());
            items_sent++;
         end
      end
      req_tvalid <= 1'b0;
      while (results_seen < items_sent) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Fed %0d samples (%0d directed, the rest random over four idling mixes).",
               items_sent, DIRECTED_COUNT);
      $display("Checked %0d results, %0d errors.", results_seen, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
